>>> src/ffa_pkg.sv
package ffa_pkg;

  localparam int ADDR_W   = 12;
  localparam int STATUS_W = 3;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_TOO_LARGE = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NO_SPACE  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NULL      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_OUTSIDE   = 3'd4;
  localparam logic [STATUS_W-1:0] ST_NOT_ALLOC = 3'd5;

endpackage

>>> src/ffa_hdr_ram.sv
// Single-port-write / single-port-read header memory, registered read.
module ffa_hdr_ram #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12,
  parameter int DW    = 13
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> src/first_fit_heap_allocator.sv
// First-fit heap allocator over a byte heap with in-band block headers.
// Each header (size, used flag) sits in one synchronous memory indexed by
// byte offset. Issue a request by raising start while busy is low; the
// result shows up on out_granted_address / out_status for exactly one
// cycle with out_valid high, and the receiver cannot stall it, so sample
// it on that beat. Each step of the chain walk is one read of the header
// memory, which has a registered read. An allocate walks the chain from
// offset 0 to the first free block that fits, plus a further write of
// the remainder header when that block is split; a too-large request
// returns without a walk. A free walks the chain up to the target, then
// reads the next header if there is one and writes back the merged header;
// null and out-of-range frees return without a walk. After reset the block
// writes the initial whole-heap header with busy high.
// Reads and writes never fall in the same cycle, so no forwarding is needed.
module first_fit_heap_allocator
  import ffa_pkg::*;
#(
  parameter int HEAP_BYTES   = 4096,
  parameter int HEADER_BYTES = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic                in_kind,
  input  logic [ADDR_W-1:0]   in_request_size,
  input  logic [ADDR_W-1:0]   in_address,
  output logic                out_valid,
  output logic [ADDR_W-1:0]   out_granted_address,
  output logic [STATUS_W-1:0] out_status
);

  // index width, size width, and a compute width that holds HEAP_BYTES and
  // any 12-bit input plus a header
  localparam int AW = $clog2(HEAP_BYTES);
  localparam int SW = AW;
  localparam int DW = SW + 1;
  localparam int PW = AW + 1;
  localparam int CW = (PW > ADDR_W + 1) ? PW : ADDR_W + 1;

  localparam logic [CW-1:0] HEAP_C  = CW'(HEAP_BYTES);
  localparam logic [CW-1:0] HDR_C   = CW'(HEADER_BYTES);
  localparam logic [CW-1:0] MAXREQ  = CW'(HEAP_BYTES - HEADER_BYTES);
  localparam logic [SW-1:0] INIT_SZ = SW'(HEAP_BYTES - HEADER_BYTES);

  localparam logic [2:0] S_INIT    = 3'd0;
  localparam logic [2:0] S_IDLE    = 3'd1;
  localparam logic [2:0] S_A_CHK   = 3'd2;
  localparam logic [2:0] S_A_SPLIT = 3'd3;
  localparam logic [2:0] S_F_WALK  = 3'd4;
  localparam logic [2:0] S_F_NEXT  = 3'd5;
  localparam logic [2:0] S_F_MERGE = 3'd6;

  logic [2:0]          state_r, state_nxt;
  logic [CW-1:0]       p_r, p_nxt;          // current header offset
  logic [CW-1:0]       req_r, req_nxt;      // request size (alloc)
  logic [CW-1:0]       tgt_r, tgt_nxt;      // header offset to free
  logic [CW-1:0]       prev_r, prev_nxt;
  logic [SW-1:0]       prev_size_r, prev_size_nxt;
  logic                prev_used_r, prev_used_nxt;
  logic                have_prev_r, have_prev_nxt;
  logic [SW-1:0]       t_size_r, t_size_nxt; // target size / split remainder
  logic                out_valid_r, out_valid_nxt;
  logic [ADDR_W-1:0]   out_addr_r, out_addr_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;

  // header memory port
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [DW-1:0] rd_data;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [DW-1:0] wr_data;

  ffa_hdr_ram #(
    .DEPTH (HEAP_BYTES),
    .AW    (AW),
    .DW    (DW)
  ) u_hdr_ram (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  // decoded header of the block read last cycle
  logic          hdr_used;
  logic [SW-1:0] hdr_size;
  logic [CW-1:0] hdr_next;   // offset of the following block
  logic [CW-1:0] in_req_c;
  logic [CW-1:0] in_addr_c;
  logic [CW-1:0] in_tgt_c;
  logic [CW-1:0] split_at;

  assign hdr_used  = rd_data[SW];
  assign hdr_size  = rd_data[SW-1:0];
  assign hdr_next  = p_r + HDR_C + CW'(hdr_size);
  assign in_req_c  = CW'(in_request_size);
  assign in_addr_c = CW'(in_address);
  assign in_tgt_c  = in_addr_c - HDR_C;
  assign split_at  = p_r + HDR_C + req_r;

  assign busy                = (state_r != S_IDLE);
  assign out_valid           = out_valid_r;
  assign out_granted_address = out_addr_r;
  assign out_status          = out_status_r;

  always_comb begin
    state_nxt      = state_r;
    p_nxt          = p_r;
    req_nxt        = req_r;
    tgt_nxt        = tgt_r;
    prev_nxt       = prev_r;
    prev_size_nxt  = prev_size_r;
    prev_used_nxt  = prev_used_r;
    have_prev_nxt  = have_prev_r;
    t_size_nxt     = t_size_r;
    out_valid_nxt  = 1'b0;
    out_addr_nxt   = out_addr_r;
    out_status_nxt = out_status_r;
    rd_en          = 1'b0;
    rd_addr        = '0;
    wr_en          = 1'b0;
    wr_addr        = '0;
    wr_data        = '0;

    unique case (state_r)
      S_INIT: begin
        // entry 0: one free block spanning the heap
        wr_en     = 1'b1;
        wr_addr   = '0;
        wr_data   = {1'b0, INIT_SZ};
        state_nxt = S_IDLE;
      end

      S_IDLE: begin
        if (start) begin
          req_nxt       = in_req_c;
          tgt_nxt       = in_tgt_c;
          p_nxt         = '0;
          have_prev_nxt = 1'b0;
          out_addr_nxt  = '0;
          if (in_kind == KIND_ALLOC) begin
            if (in_req_c > MAXREQ) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = ST_TOO_LARGE;
            end else begin
              rd_en     = 1'b1;
              state_nxt = S_A_CHK;
            end
          end else begin
            priority if (in_address == '0) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = ST_NULL;
            end else if (in_addr_c < HDR_C || in_tgt_c >= HEAP_C) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = ST_OUTSIDE;
            end else begin
              rd_en     = 1'b1;
              state_nxt = S_F_WALK;
            end
          end
        end
      end

      S_A_CHK: begin
        priority if (!hdr_used && CW'(hdr_size) >= req_r + HDR_C + CW'(1)) begin
          // split: grant the front, remainder header written next cycle
          wr_en      = 1'b1;
          wr_addr    = p_r[AW-1:0];
          wr_data    = {1'b1, req_r[SW-1:0]};
          t_size_nxt = SW'(CW'(hdr_size) - req_r - HDR_C);
          state_nxt  = S_A_SPLIT;
        end else if (!hdr_used && CW'(hdr_size) >= req_r) begin
          wr_en          = 1'b1;
          wr_addr        = p_r[AW-1:0];
          wr_data        = {1'b1, hdr_size};
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_OK;
          out_addr_nxt   = ADDR_W'(p_r + HDR_C);
          state_nxt      = S_IDLE;
        end else if (hdr_next >= HEAP_C) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_NO_SPACE;
          state_nxt      = S_IDLE;
        end else begin
          p_nxt   = hdr_next;
          rd_en   = 1'b1;
          rd_addr = hdr_next[AW-1:0];
        end
      end

      S_A_SPLIT: begin
        wr_en          = 1'b1;
        wr_addr        = split_at[AW-1:0];
        wr_data        = {1'b0, t_size_r};
        out_valid_nxt  = 1'b1;
        out_status_nxt = ST_OK;
        out_addr_nxt   = ADDR_W'(p_r + HDR_C);
        state_nxt      = S_IDLE;
      end

      S_F_WALK: begin
        if (p_r == tgt_r) begin
          if (!hdr_used) begin
            // double free
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_NOT_ALLOC;
            state_nxt      = S_IDLE;
          end else begin
            t_size_nxt = hdr_size;
            if (hdr_next < HEAP_C) begin
              p_nxt     = hdr_next;
              rd_en     = 1'b1;
              rd_addr   = hdr_next[AW-1:0];
              state_nxt = S_F_NEXT;
            end else begin
              state_nxt = S_F_MERGE;
            end
          end
        end else if (hdr_next >= HEAP_C || hdr_next > tgt_r) begin
          // walked past the address: not a block start
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_NOT_ALLOC;
          state_nxt      = S_IDLE;
        end else begin
          prev_nxt      = p_r;
          prev_size_nxt = hdr_size;
          prev_used_nxt = hdr_used;
          have_prev_nxt = 1'b1;
          p_nxt         = hdr_next;
          rd_en         = 1'b1;
          rd_addr       = hdr_next[AW-1:0];
        end
      end

      S_F_NEXT: begin
        // absorb a free next block
        if (!hdr_used) begin
          t_size_nxt = SW'(CW'(t_size_r) + HDR_C + CW'(hdr_size));
        end
        state_nxt = S_F_MERGE;
      end

      S_F_MERGE: begin
        wr_en = 1'b1;
        if (have_prev_r && !prev_used_r) begin
          // previous block absorbs the freed one; its header drops off the chain
          wr_addr = prev_r[AW-1:0];
          wr_data = {1'b0, SW'(CW'(prev_size_r) + HDR_C + CW'(t_size_r))};
        end else begin
          wr_addr = tgt_r[AW-1:0];
          wr_data = {1'b0, t_size_r};
        end
        out_valid_nxt  = 1'b1;
        out_status_nxt = ST_OK;
        out_addr_nxt   = '0;
        state_nxt      = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p_r          <= p_nxt;
    req_r        <= req_nxt;
    tgt_r        <= tgt_nxt;
    prev_r       <= prev_nxt;
    prev_size_r  <= prev_size_nxt;
    prev_used_r  <= prev_used_nxt;
    have_prev_r  <= have_prev_nxt;
    t_size_r     <= t_size_nxt;
    out_addr_r   <= out_addr_nxt;
    out_status_r <= out_status_nxt;
  end

endmodule
